// ===== sv/assert_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers, compiled out for synthesis.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== sv/skt_pkg.sv =====
// -----------------------------------------------------------------------------
// Sorted key table package
// Transaction types, command codes and status codes shared by the block.
// -----------------------------------------------------------------------------
package skt_pkg;

    localparam logic [2:0] KIND_INSERT     = 3'd0;
    localparam logic [2:0] KIND_DELETE     = 3'd1;
    localparam logic [2:0] KIND_SEARCH     = 3'd2;
    localparam logic [2:0] KIND_CLEAR      = 3'd3;
    localparam logic [2:0] KIND_NEXT       = 3'd4;
    localparam logic [2:0] KIND_ITER_RESET = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_WRAPPED   = 3'd4;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] key;
    } t_skt_in;

    typedef struct packed {
        logic [2:0]         status;
        logic [3:0]         position;
        logic signed [31:0] entry_value;
        logic [4:0]         occupancy;
    } t_skt_out;

    typedef struct packed {
        logic capture;
        logic apply;
    } t_skt_cmd;

endpackage

// ===== sv/sorted_key_table_unit.sv =====
// -----------------------------------------------------------------------------
// Sorted key table unit
// A transaction is captured into the compare registers, then applied to the table
// and result register; busy from the capture/apply sequencer holds off a new one until then.
// The result strobe stands for one cycle; the receiver cannot stall it.
// Synchronous active-low reset empties the table and puts the iterator at none.
// -----------------------------------------------------------------------------
module sorted_key_table_unit import skt_pkg::*; #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_skt_in  i_item,
    output logic     o_valid,
    output t_skt_out o_result
);

    t_skt_cmd w_cmd;

    skt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd),
        .o_valid (o_valid)
    );

    skt_dp #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule

// ===== sv/skt_ctrl.sv =====
// -----------------------------------------------------------------------------
// Sorted key table controller
// Two-state sequencer: capture a transaction, then apply it and strobe result.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module skt_ctrl import skt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output t_skt_cmd o_cmd,
    output logic     o_valid
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= o_cmd.apply;
        end
    end

    assign busy          = (r_state == S_EXEC);
    assign o_cmd.capture = start && !busy;
    assign o_cmd.apply   = busy;
    assign o_valid       = r_valid;

    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy)
    `ASSERT_CLK(a_exec_strobe, i_clk, i_rst_n, busy |=> (o_valid && !busy))
    `ASSERT_CLK(a_strobe_src, i_clk, i_rst_n, o_valid |-> $past(busy))

endmodule

// ===== sv/skt_dp.sv =====
// -----------------------------------------------------------------------------
// Sorted key table datapath
// Per-entry compare row, parallel shift register table, iterator and result.
// -----------------------------------------------------------------------------
module skt_dp import skt_pkg::*; #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_skt_cmd i_cmd,
    input  t_skt_in  i_item,
    output t_skt_out o_result
);

    localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [KW-1:0] r_entry [CAPACITY];
    logic signed [KW-1:0] n_entry [CAPACITY];
    logic [CW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_iter, n_iter;
    logic                 r_active, n_active;

    logic [2:0]           r_kind;
    logic signed [KW-1:0] r_key;
    logic [CAPACITY-1:0]  r_lt, r_eq;
    t_skt_out             r_result, n_result;

    logic signed [KW-1:0] w_key;
    logic [CAPACITY-1:0]  w_lt, w_eq;
    logic [CAPACITY-1:0]  w_first, w_prev_ge;
    logic [IW-1:0]        w_pos, w_sel;
    logic                 w_found, w_empty, w_full, w_ins, w_del;

    assign w_key = KW'(i_item.key);

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_lt[i] = (CW'(i) < r_count) && (r_entry[i] < w_key);
            w_eq[i] = (CW'(i) < r_count) && (r_entry[i] == w_key);
        end
    end

    assign w_first   = ~r_lt & {r_lt[CAPACITY-2:0], 1'b1};
    assign w_prev_ge = {~r_lt[CAPACITY-2:0], 1'b0};
    assign w_found   = |(w_first & r_eq);
    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count >= CW'(CAPACITY));
    assign w_ins     = (r_kind == KIND_INSERT) && !w_full;
    assign w_del     = (r_kind == KIND_DELETE) && !w_empty && w_found;
    assign w_sel     = r_active ? IW'(r_iter + 1'b1) : '0;

    always_comb begin
        w_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_pos = w_pos | (w_first[i] ? IW'(i) : '0);
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_entry[i] = r_entry[i];
        end
        if (w_ins) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (w_first[i]) begin
                    n_entry[i] = r_key;
                end else if (w_prev_ge[i]) begin
                    n_entry[i] = r_entry[(i + CAPACITY - 1) % CAPACITY];
                end
            end
        end else if (w_del) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (!r_lt[i]) n_entry[i] = r_entry[i + 1];
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_iter   = r_iter;
        n_active = r_active;
        n_result = '0;
        case (r_kind)
            KIND_INSERT: begin
                if (w_full) begin
                    n_result.status = ST_FULL;
                end else begin
                    n_count           = r_count + 1'b1;
                    n_result.position = 4'(w_pos);
                    n_iter            = '0;
                    n_active          = 1'b0;
                end
            end
            KIND_DELETE: begin
                if (w_empty) begin
                    n_result.status = ST_EMPTY;
                end else if (!w_found) begin
                    n_result.status = ST_NOT_FOUND;
                end else begin
                    n_count           = r_count - 1'b1;
                    n_result.position = 4'(w_pos);
                    n_iter            = '0;
                    n_active          = 1'b0;
                end
            end
            KIND_SEARCH: begin
                if (w_empty) begin
                    n_result.status = ST_EMPTY;
                end else if (!w_found) begin
                    n_result.status = ST_NOT_FOUND;
                end else begin
                    n_result.position = 4'(w_pos);
                end
            end
            KIND_CLEAR: begin
                if (w_empty) begin
                    n_result.status = ST_EMPTY;
                end else begin
                    n_count  = '0;
                    n_iter   = '0;
                    n_active = 1'b0;
                end
            end
            KIND_NEXT: begin
                if (w_empty) begin
                    n_result.status = ST_EMPTY;
                end else if (r_active && (CW'(r_iter) + 1'b1 >= r_count)) begin
                    n_result.status = ST_WRAPPED;
                    n_iter          = '0;
                    n_active        = 1'b0;
                end else begin
                    n_iter               = w_sel;
                    n_active             = 1'b1;
                    n_result.position    = 4'(w_sel);
                    n_result.entry_value = 32'(r_entry[w_sel]);
                end
            end
            KIND_ITER_RESET: begin
                n_iter   = '0;
                n_active = 1'b0;
            end
            default: begin
            end
        endcase
        n_result.occupancy = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_iter   <= '0;
            r_active <= 1'b0;
        end else if (i_cmd.apply) begin
            r_count  <= n_count;
            r_iter   <= n_iter;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_item.kind;
            r_key  <= w_key;
            r_lt   <= w_lt;
            r_eq   <= w_eq;
        end
        if (i_cmd.apply) begin
            r_result <= n_result;
            for (int i = 0; i < CAPACITY; i++) begin
                r_entry[i] <= n_entry[i];
            end
        end
    end

    assign o_result = r_result;

endmodule

// ===== sim/sorted_key_table_unit_test.sv =====
// -----------------------------------------------------------------------------
// Sorted key table unit testbench
// Sends command transactions to the table and models the sorted table and its
// iterator alongside. Each result strobe is checked field by field against the
// oldest predicted result. Directed cases come first, then bursty random traffic.
// -----------------------------------------------------------------------------
module sorted_key_table_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import skt_pkg::*;

    localparam int TABLE_DEPTH    = 16;
    localparam int RANDOM_ITEMS   = 900;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    logic     busy;
    t_skt_in  i_item  = '0;
    logic     o_valid;
    t_skt_out o_result;

    logic signed [31:0] table_keys [TABLE_DEPTH];
    int                 table_count = 0;
    int                 iter_pos    = 0;
    bit                 iter_live   = 1'b0;
    t_skt_out           pending_results [$];
    int                 mismatch_count = 0;
    int                 idle_cycles    = 0;

    always #2ns i_clk = ~i_clk;

    sorted_key_table_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    function automatic int locate_key(input logic signed [31:0] key);
        int idx;
        for (idx = 0; idx < table_count; idx++) begin
            if (table_keys[idx] == key) begin
                return idx;
            end
            if (table_keys[idx] > key) begin
                break;
            end
        end
        return table_count;
    endfunction

    function automatic void drop_iterator();
        iter_live = 1'b0;
        iter_pos  = 0;
    endfunction

    function automatic t_skt_out predict_result(input t_skt_in cmd);
        t_skt_out           res;
        logic signed [31:0] key;
        int                 idx;
        int                 j;
        res = '0;
        key = cmd.key;
        case (cmd.kind)
            KIND_INSERT: begin
                if (table_count >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    idx = 0;
                    while (idx < table_count && table_keys[idx] < key) idx++;
                    for (j = table_count; j > idx; j--) table_keys[j] = table_keys[j - 1];
                    table_keys[idx] = key;
                    table_count++;
                    res.position = 4'(idx);
                    drop_iterator();
                end
            end
            KIND_DELETE: begin
                idx = locate_key(key);
                if (table_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (idx >= table_count) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    for (j = idx; j < table_count - 1; j++) table_keys[j] = table_keys[j + 1];
                    table_count--;
                    res.position = 4'(idx);
                    drop_iterator();
                end
            end
            KIND_SEARCH: begin
                idx = locate_key(key);
                if (table_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (idx >= table_count) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.position = 4'(idx);
                end
            end
            KIND_CLEAR: begin
                if (table_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    table_count = 0;
                    drop_iterator();
                end
            end
            KIND_NEXT: begin
                if (table_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (iter_live && iter_pos + 1 >= table_count) begin
                    drop_iterator();
                    res.status = ST_WRAPPED;
                end else begin
                    if (iter_live) begin
                        iter_pos++;
                    end else begin
                        iter_live = 1'b1;
                        iter_pos  = 0;
                    end
                    res.position    = 4'(iter_pos);
                    res.entry_value = table_keys[iter_pos];
                end
            end
            KIND_ITER_RESET: begin
                drop_iterator();
            end
            default: begin
            end
        endcase
        res.occupancy = 5'(table_count);
        return res;
    endfunction

    function automatic void log_fault(input string what, input t_skt_out want,
                                      input t_skt_out got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%s: expected st=%0d pos=%0d val=%0d occ=%0d", what, want.status,
                     want.position, want.entry_value, want.occupancy);
            $display("    got st=%0d pos=%0d val=%0d occ=%0d", got.status, got.position,
                     got.entry_value, got.occupancy);
        end
    endfunction

    always @(posedge i_clk) begin
        t_skt_out want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                log_fault("unexpected result", '0, o_result);
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status || o_result.position !== want.position ||
                    o_result.entry_value !== want.entry_value ||
                    o_result.occupancy !== want.occupancy) begin
                    log_fault("result mismatch", want, o_result);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_command(input logic [2:0] op, input logic signed [31:0] key_val);
        t_skt_in cmd;
        cmd.kind = op;
        cmd.key  = key_val;
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= cmd;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(predict_result(cmd));
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic walk_iterator();
        int steps;
        steps = table_count + 1;
        repeat (steps) send_command(KIND_NEXT, $urandom());
    endtask

    function automatic logic signed [31:0] pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45 && table_count > 0) begin
            return table_keys[$urandom_range(0, table_count - 1)];
        end
        if (sel < 70) begin
            return int'($urandom_range(0, 40)) - 20;
        end
        if (sel < 78) begin
            case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom();
    endfunction

    function automatic logic [2:0] pick_kind(input bit filling);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < (filling ? 55 : 20)) begin
            return KIND_INSERT;
        end
        if (roll < (filling ? 65 : 50)) begin
            return KIND_DELETE;
        end
        if (roll < 78) begin
            return KIND_SEARCH;
        end
        if (roll < 91) begin
            return KIND_NEXT;
        end
        if (roll < 94) begin
            return KIND_ITER_RESET;
        end
        if (roll < 97) begin
            return KIND_CLEAR;
        end
        return $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
    endfunction

    task automatic test_empty_table();
        send_command(KIND_NEXT, 32'sd0);
        send_command(KIND_SEARCH, 32'sd5);
        send_command(KIND_DELETE, 32'sd5);
        send_command(KIND_CLEAR, 32'sd0);
        send_command(KIND_ITER_RESET, 32'sd0);
        send_command(KIND_SPARE_A, -32'sd1);
        send_command(KIND_SPARE_B, 32'sh7fff_ffff);
    endtask

    task automatic test_order_and_duplicates();
        send_command(KIND_INSERT, 32'sh7fff_ffff);
        send_command(KIND_INSERT, 32'sh8000_0000);
        send_command(KIND_INSERT, 32'sd0);
        send_command(KIND_INSERT, 32'sd0);
        send_command(KIND_INSERT, -32'sd1);
        send_command(KIND_SEARCH, 32'sd0);
        send_command(KIND_SEARCH, 32'sd7);
        send_command(KIND_DELETE, 32'sd7);
        send_command(KIND_DELETE, 32'sh8000_0000);
    endtask

    task automatic test_iterator();
        walk_iterator();
        send_command(KIND_NEXT, 32'sd0);
        send_command(KIND_ITER_RESET, 32'sd0);
        send_command(KIND_NEXT, 32'sd0);
        send_command(KIND_INSERT, 32'sd3);
        send_command(KIND_NEXT, 32'sd0);
        send_command(KIND_CLEAR, 32'sd0);
    endtask

    task automatic test_full_table();
        while (table_count < TABLE_DEPTH) send_command(KIND_INSERT, pick_key());
        send_command(KIND_INSERT, pick_key());
        wait_drained();
        send_command(KIND_SEARCH, pick_key());
        send_command(KIND_DELETE, pick_key());
        send_command(KIND_INSERT, 32'sh8000_0000);
        walk_iterator();
        send_command(KIND_CLEAR, 32'sd0);
    endtask

    task automatic test_random_traffic();
        int sent;
        int burst_left;
        bit filling;
        sent       = 0;
        burst_left = 0;
        while (sent < RANDOM_ITEMS) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0) begin
                    hold_off($urandom_range(1, 9));
                end
            end
            filling = ((sent / 120) % 2) == 0;
            if ($urandom_range(0, 39) == 0) begin
                sent += table_count + 1;
                walk_iterator();
            end else begin
                send_command(pick_kind(filling), pick_key());
                sent++;
            end
            if ($urandom_range(0, 99) == 0) begin
                wait_drained();
            end
            burst_left--;
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_order_and_duplicates();
        test_iterator();
        test_full_table();
        test_random_traffic();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
